/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// Depends on nothing; each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

/* hdl/pst_pkg.sv */
// Shared types and constants of the periodic slot task scheduler.
// Used by the slot cells, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package pst_pkg;

  // Default number of slots in the table.
  localparam int NUM_SLOTS_DEF = 8;

  // Width of a slot interval and counter.
  localparam int TICK_W = 32;

  // Operation codes of a request.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ATTACH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // One request.
  typedef struct packed {
    logic [1:0]        operation;
    logic [TICK_W-1:0] interval;
    logic [2:0]        slot_index;
  } pst_in_t;

  // One result.
  typedef struct packed {
    logic [7:0] fire_mask;
    logic       error;
    logic [2:0] assigned_slot;
    logic [3:0] occupied_count;
  } pst_out_t;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic tick;   // advance the counter
    logic load;   // take a new interval, counter to zero
    logic shift;  // take the upper neighbor's entry
    logic clear;  // vacate the slot
  } pst_cell_ctl_t;

endpackage

/* hdl/pst_cell.sv */
// One slot of the scheduler table: interval and running counter.
// Depends on pst_pkg for the control struct and the tick width.
`timescale 1ns / 1ps

module pst_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pst_pkg::pst_cell_ctl_t        ctl,
  input  logic [pst_pkg::TICK_W-1:0]    load_interval,
  input  logic [pst_pkg::TICK_W-1:0]    nbr_interval,
  input  logic [pst_pkg::TICK_W-1:0]    nbr_counter,
  output logic [pst_pkg::TICK_W-1:0]    interval,
  output logic [pst_pkg::TICK_W-1:0]    counter,
  output logic                          is_zero
);

  logic [pst_pkg::TICK_W-1:0] interval_r, interval_nxt;
  logic [pst_pkg::TICK_W-1:0] counter_r, counter_nxt;
  logic [pst_pkg::TICK_W-1:0] counter_inc;

  // Advance by one; passing the interval returns the counter to zero.
  assign counter_inc = counter_r + pst_pkg::TICK_W'(1);

  // Next entry; the control bits never overlap, order is for clarity only.
  always_comb begin
    interval_nxt = interval_r;
    counter_nxt  = counter_r;
    priority if (ctl.clear) begin
      interval_nxt = '0;
      counter_nxt  = '0;
    end else if (ctl.shift) begin
      interval_nxt = nbr_interval;
      counter_nxt  = nbr_counter;
    end else if (ctl.load) begin
      interval_nxt = load_interval;
      counter_nxt  = '0;
    end else if (ctl.tick) begin
      counter_nxt = (counter_inc > interval_r) ? '0 : counter_inc;
    end else begin
      // No request touches this slot: hold the entry.
      interval_nxt = interval_r;
      counter_nxt  = counter_r;
    end
  end

  // Slot registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
      counter_r  <= '0;
    end else begin
      interval_r <= interval_nxt;
      counter_r  <= counter_nxt;
    end
  end

  assign interval = interval_r;
  assign counter  = counter_r;
  assign is_zero  = (counter_r == '0);

endmodule

/* hdl/periodic_slot_task_scheduler_unit.sv */
// Top level of the periodic slot task scheduler: a row of slot cells.
// Depends on pst_pkg and pst_cell.
`timescale 1ns / 1ps

// Usage
// A request is taken at a rising edge with start high and busy low. busy
// stays low, so a request may be given in every cycle. The request carries
// an operation (tick, attach, remove), an interval for attach and a slot
// index for remove.
// Each request gives exactly one result, shown on out_rsp for one cycle with
// out_valid high, in the cycle right after the request was taken.
// Throughput is one request per cycle: every cell updates its own interval
// and counter in the same edge, and a remove moves each later entry one cell
// down the row in that edge.
// The receiver cannot stall: the result must be taken in the cycle it shows.
// Synchronous reset (rst_n low) empties the table, clears every cell and
// drops out_valid; no clearing pass is needed afterwards.
// The fire mask covers the first eight slots; further slots run normally.

module periodic_slot_task_scheduler_unit #(
  parameter int NUM_SLOTS = pst_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pst_pkg::pst_in_t  in_req,
  output logic              out_valid,
  output pst_pkg::pst_out_t out_rsp
);

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CMP_W-1:0] used_ext, idx_ext, used_nxt_ext;
  logic             accept;
  logic             is_tick, is_attach, is_remove;
  logic             tick_ok, attach_ok, remove_ok;
  logic             out_valid_r;
  pst_pkg::pst_out_t out_rsp_r, out_rsp_nxt;

  pst_pkg::pst_cell_ctl_t            ctl      [NUM_SLOTS];
  logic [pst_pkg::TICK_W-1:0]        ivl_row  [NUM_SLOTS];
  logic [pst_pkg::TICK_W-1:0]        cnt_row  [NUM_SLOTS];
  logic [pst_pkg::TICK_W-1:0]        nbr_ivl  [NUM_SLOTS];
  logic [pst_pkg::TICK_W-1:0]        nbr_cnt  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]              zero_vec;
  logic [NUM_SLOTS-1:0]              occ_vec;
  logic [7:0]                        fire_mask;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decode the request and check it against the fill level.
  assign used_ext  = CMP_W'(used_r);
  assign idx_ext   = CMP_W'(in_req.slot_index);
  assign is_tick   = accept && (in_req.operation == pst_pkg::OP_TICK);
  assign is_attach = accept && (in_req.operation == pst_pkg::OP_ATTACH);
  assign is_remove = accept && (in_req.operation == pst_pkg::OP_REMOVE);
  assign tick_ok   = is_tick && (used_r != '0);
  assign attach_ok = is_attach && (used_r != CNT_W'(NUM_SLOTS));
  assign remove_ok = is_remove && (used_r != '0) && (idx_ext < used_ext);

  // Row of cells; a remove moves each entry above the index one cell down.
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    assign occ_vec[i]   = (CMP_W'(i) < used_ext);
    assign ctl[i].tick  = tick_ok && occ_vec[i];
    assign ctl[i].load  = attach_ok && (CMP_W'(i) == used_ext);
    assign ctl[i].shift = remove_ok && (CMP_W'(i) >= idx_ext) &&
                          (CMP_W'(i + 1) < used_ext);
    assign ctl[i].clear = remove_ok && (CMP_W'(i + 1) == used_ext);

    if (i + 1 < NUM_SLOTS) begin : g_nbr
      assign nbr_ivl[i] = ivl_row[i + 1];
      assign nbr_cnt[i] = cnt_row[i + 1];
    end else begin : g_end
      assign nbr_ivl[i] = '0;
      assign nbr_cnt[i] = '0;
    end

    pst_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl[i]),
      .load_interval (in_req.interval),
      .nbr_interval  (nbr_ivl[i]),
      .nbr_counter   (nbr_cnt[i]),
      .interval      (ivl_row[i]),
      .counter       (cnt_row[i]),
      .is_zero       (zero_vec[i])
    );
  end

  // Fire mask over the first eight slots.
  for (genvar m = 0; m < 8; m++) begin : g_mask
    if (m < NUM_SLOTS) begin : g_on
      assign fire_mask[m] = tick_ok && occ_vec[m] && zero_vec[m];
    end else begin : g_off
      assign fire_mask[m] = 1'b0;
    end
  end

  // Fill level after this request.
  always_comb begin
    used_nxt = used_r;
    priority if (attach_ok) begin
      used_nxt = used_r + CNT_W'(1);
    end else if (remove_ok) begin
      used_nxt = used_r - CNT_W'(1);
    end else begin
      used_nxt = used_r;
    end
  end

  assign used_nxt_ext = CMP_W'(used_nxt);

  // Result of this request.
  always_comb begin
    out_rsp_nxt.fire_mask      = fire_mask;
    out_rsp_nxt.error          = !(tick_ok || attach_ok || remove_ok);
    out_rsp_nxt.assigned_slot  = attach_ok ? used_ext[2:0] : 3'd0;
    out_rsp_nxt.occupied_count = used_nxt_ext[3:0];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      out_valid_r <= accept;
    end
  end

  // Result register, loaded only when a request is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

/* hdl/pst_checker.sv */
// Port-level checks of the periodic slot task scheduler, bound to the top.
// Depends on pst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pst_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input pst_pkg::pst_in_t  in_req,
  input logic              out_valid,
  input pst_pkg::pst_out_t out_rsp
);

  // Every taken request gives a result in the next cycle.
  `ASSERT_CLK(a_req_gives_rsp, (rst_n && start && !busy) |=> out_valid, "request without result")

  // No result without a request in the cycle before.
  `ASSERT_CLK(a_no_stray_rsp, (!(start && !busy)) |=> !out_valid, "result without request")

  // A rejected request fires nothing and assigns no slot.
  `ASSERT_CLK(a_err_quiet, (out_valid && out_rsp.error) |-> (out_rsp.fire_mask == 8'd0 && out_rsp.assigned_slot == 3'd0), "rejected request with payload")

  // A tick that is not rejected means the table is not empty.
  `ASSERT_CLK(a_tick_nonempty, (rst_n && start && !busy && in_req.operation == pst_pkg::OP_TICK) |=> (out_rsp.error || out_rsp.occupied_count != 4'd0), "tick accepted on empty table")

  // A successful attach that assigns a slot other than zero fires nothing.
  `ASSERT_NEVER(a_mask_tick_only, out_valid && !out_rsp.error && out_rsp.assigned_slot != 3'd0 && out_rsp.fire_mask != 8'd0, "fire mask on attach")

endmodule

bind periodic_slot_task_scheduler_unit pst_checker u_pst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
